// File: hdl/esh_pkg.sv
// Shared types and constants for the energy spectrum histogrammer.
// Depends on nothing; used by the controller, the datapath and the top level.
package esh_pkg;

   localparam int CNT_W = 25;
   localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(16 * 1024 * 1024);
   localparam logic [CNT_W-1:0] PIX_MAX_INIT = CNT_W'(64);
   localparam logic [CNT_W-1:0] ENG_MAX_INIT = CNT_W'(10);

   localparam int BLK_W = 3;
   localparam int STRIP_W = 6;
   localparam int CHAN_W = 6;

   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 104;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_UPDATE
   } esh_state_type;

   typedef struct packed {
      logic clear_en;
      logic capture;
      logic read_en;
      logic commit;
   } esh_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic drop;
   } esh_status_type;

   // saturating increment of one bin
   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      r = (v < COUNT_LIMIT) ? v + CNT_W'(1) : v;
      return r;
   endfunction

endpackage

// File: hdl/energy_spectrum_histogrammer.sv
// Top level of the energy spectrum histogrammer: stream ports, packing,
// controller and datapath. Depends on esh_pkg, esh_ctrl and esh_datapath.
//
// Usage:
//   req channel carries one event or readout word. tuser selects what it is:
//   mode (count or read) and event_valid. tdata carries the bin address.
//   tlast marks the last word of a software buffer and comes back as rsp tlast.
//   A counted event bumps its strip/energy bin and its energy bin, both
//   saturating at 2^24, and raises the two running maxima (start 64 and 10).
//   A read word returns both bins unchanged; out-of-range parts read as 0.
//   Invalid or out-of-range count words produce no response word.
// Timing:
//   Each word passes accept, bin memory read, then update and write back; the
//   next word is accepted only after that update. The response is registered
//   at the end of the update step, once the output slot is free.
// Reset:
//   After reset a clearing pass zeroes both memories, one entry per cycle, over
//   NUM_BLOCKS*NUM_STRIPS*NUM_CHANNELS entries (32768 at default); req_tready
//   stays low meanwhile.
// Stall:
//   A held response stays in the output register; the next word is still accepted
//   and processed; one yielding a response waits in update until the slot frees.
module energy_spectrum_histogrammer #(
   parameter int NUM_BLOCKS   = 8,
   parameter int NUM_STRIPS   = 64,
   parameter int NUM_CHANNELS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [2:0] block_index, [8:3] strip_index, [14:9] energy_channel, [15] zero
   input  logic [esh_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] mode, [1] event_valid
   input  logic [esh_pkg::REQ_USER_W-1:0]     req_tuser,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [24:0] pixel_count, [49:25] energy_count, [74:50] max_pixel_count,
   // [99:75] max_energy_count, [103:100] zero
   output logic [esh_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast
);
   import esh_pkg::*;

   esh_cmd_type      cmd;
   esh_status_type   status;
   logic [CNT_W-1:0] pix_cnt, eng_cnt, max_pix, max_eng;

   esh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   esh_datapath #(
      .NUM_BLOCKS   (NUM_BLOCKS),
      .NUM_STRIPS   (NUM_STRIPS),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .in_mode              (req_tuser[0]),
      .in_event_valid       (req_tuser[1]),
      .in_block_index       (req_tdata[2:0]),
      .in_strip_index       (req_tdata[8:3]),
      .in_energy_channel    (req_tdata[14:9]),
      .in_buffer_end        (req_tlast),
      .out_pixel_count      (pix_cnt),
      .out_energy_count     (eng_cnt),
      .out_max_pixel_count  (max_pix),
      .out_max_energy_count (max_eng),
      .out_batch_done       (rsp_tlast)
   );

   // pack response fields, lowest field first
   assign rsp_tdata = {4'b0000, max_eng, max_pix, eng_cnt, pix_cnt};

endmodule

// File: hdl/esh_ctrl.sv
// Controller state machine of the histogrammer: clearing pass, accept,
// memory read and update/commit. Depends on esh_pkg.
module esh_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output esh_pkg::esh_cmd_type    cmd,
   input  esh_pkg::esh_status_type status
);
   import esh_pkg::*;

   esh_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.read_en = 1'b1;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold until the output slot is free, unless nothing is produced
            if (status.drop || !rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase

      if (cmd.commit && !status.drop) rsp_valid_in = 1'b1;
      else if (rsp_tready)            rsp_valid_in = 1'b0;
      else                            rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: hdl/esh_datapath.sv
// Datapath of the histogrammer: bin memories, address and range logic,
// saturating update, running maxima and result register. Depends on esh_pkg.
module esh_datapath #(
   parameter int NUM_BLOCKS   = 8,
   parameter int NUM_STRIPS   = 64,
   parameter int NUM_CHANNELS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  esh_pkg::esh_cmd_type              cmd,
   output esh_pkg::esh_status_type           status,
   input  logic                              in_mode,
   input  logic                              in_event_valid,
   input  logic [esh_pkg::BLK_W-1:0]         in_block_index,
   input  logic [esh_pkg::STRIP_W-1:0]       in_strip_index,
   input  logic [esh_pkg::CHAN_W-1:0]        in_energy_channel,
   input  logic                              in_buffer_end,
   output logic [esh_pkg::CNT_W-1:0]         out_pixel_count,
   output logic [esh_pkg::CNT_W-1:0]         out_energy_count,
   output logic [esh_pkg::CNT_W-1:0]         out_max_pixel_count,
   output logic [esh_pkg::CNT_W-1:0]         out_max_energy_count,
   output logic                              out_batch_done
);
   import esh_pkg::*;

   localparam int PIX_DEPTH = NUM_BLOCKS * NUM_STRIPS * NUM_CHANNELS;
   localparam int ENG_DEPTH = NUM_BLOCKS * NUM_CHANNELS;
   localparam int STRIDE    = NUM_STRIPS * NUM_CHANNELS;
   localparam int PIX_AW    = $clog2(PIX_DEPTH);
   localparam int ENG_AW    = $clog2(ENG_DEPTH);

   logic [CNT_W-1:0] pix_mem [PIX_DEPTH];
   logic [CNT_W-1:0] eng_mem [ENG_DEPTH];

   logic              mode_ff, valid_ff, last_ff, pix_ok_ff, eng_ok_ff;
   logic [PIX_AW-1:0] pa_ff, pa_in;
   logic [ENG_AW-1:0] ea_ff, ea_in;
   logic [PIX_AW-1:0] clr_ff;
   logic [CNT_W-1:0]  rd_pix_ff, rd_eng_ff;
   logic [CNT_W-1:0]  max_pix_ff, max_pix_in, max_eng_ff, max_eng_in;
   logic [CNT_W-1:0]  pix_res, eng_res;
   logic [CNT_W-1:0]  pix_new, eng_new;
   logic              blk_ok, strip_ok, chan_ok, pix_ok, eng_ok;
   logic [31:0]       pa_full, ea_full;
   logic              clr_eng, wr_en, load_out;

   // range check and flat addresses of the incoming word
   always_comb begin
      blk_ok   = 32'(in_block_index) < 32'(NUM_BLOCKS);
      strip_ok = 32'(in_strip_index) < 32'(NUM_STRIPS);
      chan_ok  = 32'(in_energy_channel) < 32'(NUM_CHANNELS);
      pix_ok   = blk_ok && strip_ok && chan_ok;
      eng_ok   = blk_ok && chan_ok;
      pa_full  = 32'(in_block_index) * 32'(STRIDE)
               + 32'(in_strip_index) * 32'(NUM_CHANNELS) + 32'(in_energy_channel);
      ea_full  = 32'(in_block_index) * 32'(NUM_CHANNELS) + 32'(in_energy_channel);
      pa_in    = pix_ok ? pa_full[PIX_AW-1:0] : '0;
      ea_in    = eng_ok ? ea_full[ENG_AW-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff   <= in_mode;
         valid_ff  <= in_event_valid;
         last_ff   <= in_buffer_end;
         pix_ok_ff <= pix_ok;
         eng_ok_ff <= eng_ok;
         pa_ff     <= pa_in;
         ea_ff     <= ea_in;
      end
   end

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset)             clr_ff <= '0;
      else if (cmd.clear_en) clr_ff <= clr_ff + PIX_AW'(1);
   end

   assign clr_eng           = 32'(clr_ff) < 32'(ENG_DEPTH);
   assign status.clear_done = clr_ff == PIX_AW'(PIX_DEPTH - 1);
   assign status.drop       = !mode_ff && !(valid_ff && pix_ok_ff);

   assign pix_new  = bump(rd_pix_ff);
   assign eng_new  = bump(rd_eng_ff);
   assign load_out = cmd.commit && !status.drop;
   assign wr_en    = load_out && !mode_ff;

   // bin memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (cmd.clear_en)  pix_mem[clr_ff] <= '0;
      else if (wr_en)    pix_mem[pa_ff]  <= pix_new;
      if (cmd.read_en)   rd_pix_ff       <= pix_mem[pa_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_en && clr_eng) eng_mem[clr_ff[ENG_AW-1:0]] <= '0;
      else if (wr_en)              eng_mem[ea_ff]              <= eng_new;
      if (cmd.read_en)             rd_eng_ff                   <= eng_mem[ea_ff];
   end

   always_comb begin
      max_pix_in = max_pix_ff;
      max_eng_in = max_eng_ff;
      if (mode_ff) begin
         pix_res = pix_ok_ff ? rd_pix_ff : '0;
         eng_res = eng_ok_ff ? rd_eng_ff : '0;
      end else begin
         pix_res = pix_new;
         eng_res = eng_new;
         if (pix_new > max_pix_ff) max_pix_in = pix_new;
         if (eng_new > max_eng_ff) max_eng_in = eng_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_pix_ff <= PIX_MAX_INIT;
         max_eng_ff <= ENG_MAX_INIT;
      end else if (load_out) begin
         max_pix_ff <= max_pix_in;
         max_eng_ff <= max_eng_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_pixel_count      <= pix_res;
         out_energy_count     <= eng_res;
         out_max_pixel_count  <= max_pix_in;
         out_max_energy_count <= max_eng_in;
         out_batch_done       <= last_ff;
      end
   end

endmodule

// File: hdl/esh_checker.sv
// Port-level checks for the histogrammer and the bind that attaches them.
// Depends on energy_spectrum_histogrammer.
module esh_port_checks (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata
);

   // one word at a time: no accept in the cycle right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req accepted on back-to-back cycles");

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // bins never pass the saturation limit
   a_saturate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[24:0] <= 25'h1000000 && rsp_tdata[49:25] <= 25'h1000000))
      else $error("bin count above limit");

   // maxima never fall below their start values
   a_max_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[74:50] >= 25'd64 && rsp_tdata[99:75] >= 25'd10))
      else $error("running maximum below start value");

endmodule

bind energy_spectrum_histogrammer esh_port_checks u_esh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
